// File: hw/rtl/ptw_pkg.sv
// Shared types and constants for the page table walker.
package ptw_pkg;

   localparam int INDEX_BITS = 9;
   localparam int VA_W       = 57;
   localparam int PA_W       = 52;
   localparam int ENTRY_W    = 64;
   localparam int FRAME_W    = 40;
   localparam int LEVEL_W    = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 40;
   localparam int REQ_DATA_W = 176;
   localparam int RSP_DATA_W = 88;
   localparam int LEAF_PAGE_W = 6;

   localparam logic [1:0] OP_MAP   = 2'd0;
   localparam logic [1:0] OP_UNMAP = 2'd1;

   localparam logic [CSR_IDX_W-1:0] REG_PAGING_LEVELS   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_POOL_BASE_FRAME = 1'd1;

   localparam logic [LEVEL_W-1:0] LEVEL_ONE  = 3'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_TWO  = 3'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_FOUR = 3'd4;
   localparam logic [LEVEL_W-1:0] LEVEL_FIVE = 3'd5;

   localparam int BIT_P  = 0;
   localparam int BIT_RW = 1;
   localparam int BIT_PS = 7;
   localparam int BIT_G  = 8;
   localparam int BIT_NX = 63;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_EVAL
   } state_type;

   typedef enum logic [1:0] {
      WS_ZERO, WS_TABLE, WS_LEAF, WS_CLRP
   } wsel_type;

   typedef enum logic [1:0] {
      STS_OK, STS_NOT_MAPPED, STS_EXHAUSTED, STS_OUTSIDE
   } status_type;

   typedef enum logic [1:0] {
      SZ_NONE, SZ_4K, SZ_2M
   } size_type;

   // Commands from the controller
   typedef struct packed {
      logic       clear;
      logic       load;
      logic       rd;
      logic       wr;
      wsel_type   wsel;
      logic       step_down;
      logic       use_new;
      logic       alloc;
      logic       finish;
      status_type st;
      logic       leaf_large;
      size_type   size;
   } cmd_type;

   // Status towards the controller
   typedef struct packed {
      logic                clear_done;
      logic                present;
      logic                ps_entry;
      logic                table_ok;
      logic                new_ok;
      logic                pool_full;
      logic                is_map;
      logic                is_unmap;
      logic                fl_ps;
      logic [LEVEL_W-1:0]  level;
      logic                out_free;
   } sts_type;

endpackage

// File: hw/rtl/page_table_walker_unit.sv
// Top level of the page table walker: controller plus datapath.
// Maps, unmaps or looks up one virtual address per request in a pool of TABLE_PAGES table
// pages (page 0 is the root). After reset a clearing pass zeroes the table store, one entry
// a cycle, before the first request is taken; configuration writes are accepted throughout.
// A request then takes an acceptance step plus one read and one evaluate/write step per
// level visited on the single-port table store; the walk can stop early. One request is
// in flight at a time; the result waits in an output register and is held until it is taken.
module page_table_walker_unit #(
   parameter int TABLE_PAGES = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // operation[1:0], virtual_address[58:2], physical_address[110:59],
   // entry_flags[174:111], zero fill [175]
   input  logic [ptw_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // status[1:0], leaf_value[65:2], leaf_page[71:66], leaf_index[80:72],
   // large_page[81], unmapped_size[83:82], invalidate_tlb[84], zero fill [87:85]
   output logic [ptw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_we,
   input  logic [ptw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ptw_pkg::CSR_DATA_W-1:0] csr_wdata
);

   ptw_pkg::cmd_type cmd;
   ptw_pkg::sts_type sts;

   ptw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ptw_datapath #(
      .TABLE_PAGES (TABLE_PAGES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// File: hw/rtl/ptw_ctrl.sv
// Walk sequencer: clearing pass, per-level read and evaluate steps.
module ptw_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  ptw_pkg::sts_type  sts,
   output ptw_pkg::cmd_type  cmd
);

   ptw_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptw_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.wsel   = ptw_pkg::WS_ZERO;
      cmd.st     = ptw_pkg::STS_OK;
      cmd.size   = ptw_pkg::SZ_NONE;
      req_tready = 1'b0;
      case (state_ff)
         ptw_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            cmd.wr    = 1'b1;
            if (sts.clear_done) state_in = ptw_pkg::ST_IDLE;
         end
         ptw_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ptw_pkg::ST_READ;
            end
         end
         ptw_pkg::ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ptw_pkg::ST_EVAL;
         end
         ptw_pkg::ST_EVAL: begin
            // hold until the result register can take a transfer
            if (sts.out_free) begin
               if (sts.level == ptw_pkg::LEVEL_ONE) begin
                  cmd.finish = 1'b1;
                  if (sts.is_map) begin
                     cmd.wr   = 1'b1;
                     cmd.wsel = ptw_pkg::WS_LEAF;
                  end else if (sts.is_unmap) begin
                     cmd.wr   = 1'b1;
                     cmd.wsel = ptw_pkg::WS_CLRP;
                     cmd.size = ptw_pkg::SZ_4K;
                  end
                  state_in = ptw_pkg::ST_IDLE;
               end else if (sts.level == ptw_pkg::LEVEL_TWO && sts.is_map && sts.fl_ps) begin
                  cmd.finish     = 1'b1;
                  cmd.leaf_large = 1'b1;
                  cmd.wr         = 1'b1;
                  cmd.wsel       = ptw_pkg::WS_LEAF;
                  state_in       = ptw_pkg::ST_IDLE;
               end else if (sts.level == ptw_pkg::LEVEL_TWO && !sts.is_map && sts.ps_entry) begin
                  cmd.finish     = 1'b1;
                  cmd.leaf_large = 1'b1;
                  if (sts.is_unmap) begin
                     cmd.wr   = 1'b1;
                     cmd.wsel = ptw_pkg::WS_CLRP;
                     cmd.size = ptw_pkg::SZ_2M;
                  end
                  state_in = ptw_pkg::ST_IDLE;
               end else if (!sts.present) begin
                  // missing table: create on map if the pool has room, fail otherwise
                  if (!sts.is_map) begin
                     cmd.finish = 1'b1;
                     cmd.st     = ptw_pkg::STS_NOT_MAPPED;
                     state_in   = ptw_pkg::ST_IDLE;
                  end else if (sts.pool_full) begin
                     cmd.finish = 1'b1;
                     cmd.st     = ptw_pkg::STS_EXHAUSTED;
                     state_in   = ptw_pkg::ST_IDLE;
                  end else begin
                     cmd.wr    = 1'b1;
                     cmd.wsel  = ptw_pkg::WS_TABLE;
                     cmd.alloc = 1'b1;
                     // flag address bits may push the new pointer out of the pool
                     if (sts.new_ok) begin
                        cmd.step_down = 1'b1;
                        cmd.use_new   = 1'b1;
                        state_in      = ptw_pkg::ST_READ;
                     end else begin
                        cmd.finish = 1'b1;
                        cmd.st     = ptw_pkg::STS_OUTSIDE;
                        state_in   = ptw_pkg::ST_IDLE;
                     end
                  end
               end else if (!sts.table_ok) begin
                  cmd.finish = 1'b1;
                  cmd.st     = ptw_pkg::STS_OUTSIDE;
                  state_in   = ptw_pkg::ST_IDLE;
               end else begin
                  cmd.step_down = 1'b1;
                  state_in      = ptw_pkg::ST_READ;
               end
            end
         end
         default: state_in = ptw_pkg::ST_IDLE;
      endcase
   end

`ifndef ASSERT_OFF
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> sts.out_free) else $error("result produced while output busy");
   a_alloc_room: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc |-> !sts.pool_full) else $error("page taken from an exhausted pool");
   a_read_eval: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |=> state_ff == ptw_pkg::ST_EVAL) else $error("read not followed by evaluate");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> $past(sts.clear_done) || state_ff == ptw_pkg::ST_IDLE)
      else $error("request taken outside idle");
`endif

endmodule

// File: hw/rtl/ptw_datapath.sv
// Table store, walk registers, configuration and result register.
module ptw_datapath #(
   parameter int TABLE_PAGES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [ptw_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ptw_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [ptw_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ptw_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  ptw_pkg::cmd_type                    cmd,
   output ptw_pkg::sts_type                    sts
);

   localparam int PAGE_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
   localparam int NFP_W  = $clog2(TABLE_PAGES + 1);
   localparam int ADDR_W = PAGE_W + ptw_pkg::INDEX_BITS;
   localparam int DEPTH  = TABLE_PAGES * (1 << ptw_pkg::INDEX_BITS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   logic [ptw_pkg::ENTRY_W-1:0] mem [DEPTH];
   logic [ptw_pkg::ENTRY_W-1:0] rdata_ff;

   logic [2:0]                     levels_ff;
   logic [ptw_pkg::FRAME_W-1:0]    base_ff;
   logic [NFP_W-1:0]               nfp_ff;
   logic [ADDR_W-1:0]              clr_ff;
   logic [1:0]                     op_ff;
   logic [ptw_pkg::VA_W-1:0]       va_ff;
   logic [ptw_pkg::PA_W-1:0]       pa_ff;
   logic [ptw_pkg::ENTRY_W-1:0]    fl_ff;
   logic [ptw_pkg::LEVEL_W-1:0]    level_ff;
   logic [PAGE_W-1:0]              page_ff;
   logic                           rsp_valid_ff;
   logic [ptw_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic                           four;
   logic [ptw_pkg::INDEX_BITS-1:0] lvl_idx;
   logic [ADDR_W-1:0]              slot, addr;
   logic [ptw_pkg::ENTRY_W-1:0]    wdata, new_table, leaf_val;
   logic [ptw_pkg::FRAME_W-1:0]    rel, new_frame, new_rel;
   logic                           out_free;

   assign four      = (levels_ff != ptw_pkg::LEVEL_FIVE);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Pick the index bits for the current level
   always_comb begin
      case (level_ff)
         3'd1:    lvl_idx = va_ff[20:12];
         3'd2:    lvl_idx = va_ff[29:21];
         3'd3:    lvl_idx = va_ff[38:30];
         3'd4:    lvl_idx = va_ff[47:39];
         3'd5:    lvl_idx = va_ff[56:48];
         default: lvl_idx = '0;
      endcase
   end

   assign slot = {page_ff, lvl_idx};
   assign addr = cmd.clear ? clr_ff : slot;

   // Decode an existing pointer and build a new one
   assign rel       = rdata_ff[51:12] - base_ff;
   assign new_frame = ptw_pkg::FRAME_W'(nfp_ff) + base_ff;
   always_comb begin
      new_table = {12'd0, new_frame, 12'd0} | fl_ff;
      new_table[ptw_pkg::BIT_PS] = 1'b0;
      new_table[ptw_pkg::BIT_G]  = 1'b0;
      new_table[ptw_pkg::BIT_NX] = 1'b0;
      if (four) new_table[ptw_pkg::BIT_RW] = 1'b1;
   end
   // Decode the created pointer as written, flag address bits included
   assign new_rel = new_table[51:12] - base_ff;

   always_comb begin
      case (cmd.wsel)
         ptw_pkg::WS_TABLE: wdata = new_table;
         ptw_pkg::WS_LEAF:  wdata = {12'd0, pa_ff} | fl_ff;
         ptw_pkg::WS_CLRP:  wdata = rdata_ff & ~(64'd1 << ptw_pkg::BIT_P);
         default:           wdata = '0;
      endcase
   end

   assign leaf_val = cmd.wr ? wdata : rdata_ff;

   // Single-port table store with registered read
   always_ff @(posedge clock) begin
      if (cmd.wr) mem[addr] <= wdata;
      if (cmd.rd) rdata_ff <= mem[addr];
   end

   // Control registers: configuration, free page, clearing sweep, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff    <= 3'd4;
         base_ff      <= '0;
         nfp_ff       <= NFP_W'(1);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               ptw_pkg::REG_PAGING_LEVELS:   levels_ff <= csr_wdata[2:0];
               ptw_pkg::REG_POOL_BASE_FRAME: base_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.alloc) nfp_ff <= nfp_ff + NFP_W'(1);
         if (cmd.clear) clr_ff <= clr_ff + ADDR_W'(1);
         if (cmd.finish)      rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // Request and walk registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_tdata[1:0];
         va_ff    <= req_tdata[58:2];
         pa_ff    <= req_tdata[110:59];
         fl_ff    <= req_tdata[174:111];
         level_ff <= four ? ptw_pkg::LEVEL_FOUR : ptw_pkg::LEVEL_FIVE;
         page_ff  <= '0;
      end else if (cmd.step_down) begin
         level_ff <= level_ff - ptw_pkg::LEVEL_W'(1);
         page_ff  <= cmd.use_new ? PAGE_W'(new_rel) : PAGE_W'(rel);
      end
   end

   // Result register; error results carry zeros
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (cmd.st == ptw_pkg::STS_OK) begin
            rsp_data_ff <= {3'd0, (cmd.size != ptw_pkg::SZ_NONE), cmd.size, cmd.leaf_large,
                            lvl_idx, ptw_pkg::LEAF_PAGE_W'(page_ff), leaf_val, cmd.st};
         end else begin
            rsp_data_ff <= {86'd0, cmd.st};
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      sts.clear_done = (clr_ff == LAST_ADDR);
      sts.present    = rdata_ff[ptw_pkg::BIT_P];
      sts.ps_entry   = rdata_ff[ptw_pkg::BIT_PS];
      sts.table_ok   = (rel < ptw_pkg::FRAME_W'(TABLE_PAGES));
      sts.new_ok     = (new_rel < ptw_pkg::FRAME_W'(TABLE_PAGES));
      sts.pool_full  = (nfp_ff >= NFP_W'(TABLE_PAGES));
      sts.is_map     = (op_ff == ptw_pkg::OP_MAP);
      sts.is_unmap   = (op_ff == ptw_pkg::OP_UNMAP);
      sts.fl_ps      = fl_ff[ptw_pkg::BIT_PS];
      sts.level      = level_ff;
      sts.out_free   = out_free;
   end

`ifndef ASSERT_OFF
   a_nfp_bound: assert property (@(posedge clock) disable iff (reset)
      nfp_ff <= NFP_W'(TABLE_PAGES)) else $error("free page count past pool size");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> $stable(rsp_data_ff))
      else $error("pending result changed");
   a_no_access_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !cmd.rd && !cmd.finish) else $error("walk during clearing pass");
`endif

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the page table walker: random and directed walks.
module tb_top;

   localparam int POOL_PAGES = 64;
   localparam logic [1:0] OP_LOOKUP = 2'd2;
   localparam logic [1:0] OP_LOOKUP_ALT = 2'd3;
   localparam logic [63:0] FL_P  = 64'h1;
   localparam logic [63:0] FL_PS = 64'h80;
   localparam logic [63:0] FL_G  = 64'h100;

   // One expected walk result
   typedef struct {
      ptw_pkg::status_type st;
      logic [63:0]         leaf;
      logic [5:0]          page;
      logic [8:0]          idx;
      logic                large_pg;
      ptw_pkg::size_type   size;
      logic                inv;
   } walk_result_type;

   // Page table predictor plus the queue of outstanding walk results
   class walk_scoreboard;
      logic [63:0]     tables [POOL_PAGES*512];
      int              next_page;
      logic [2:0]      levels;
      logic [39:0]     base;
      walk_result_type pending_walks [$];
      int              errors;
      int              status_seen [4];

      function new();
         foreach (tables[i]) tables[i] = '0;
         next_page = 1;
         levels = 3'd4;
         base = '0;
         errors = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void set_reg(logic [ptw_pkg::CSR_IDX_W-1:0] idx, logic [39:0] val);
         if (idx == ptw_pkg::REG_PAGING_LEVELS) levels = val[2:0];
         else base = val;
      endfunction

      // Follow one entry down, creating a missing table on map
      function ptw_pkg::status_type descend(int slot, logic [1:0] op, logic [63:0] fl,
                                            bit four, output int page);
         logic [63:0] e;
         logic [39:0] rel;
         e = tables[slot];
         page = 0;
         if (!e[ptw_pkg::BIT_P]) begin
            if (op != ptw_pkg::OP_MAP) return ptw_pkg::STS_NOT_MAPPED;
            if (next_page >= POOL_PAGES) return ptw_pkg::STS_EXHAUSTED;
            rel = 40'(next_page) + base;
            e = ({24'd0, rel} << 12) | (fl & ~(FL_PS | FL_G | (64'h1 << ptw_pkg::BIT_NX)));
            if (four) e[ptw_pkg::BIT_RW] = 1'b1;
            tables[slot] = e;
            next_page++;
         end
         rel = e[51:12] - base;
         if (rel >= POOL_PAGES) return ptw_pkg::STS_OUTSIDE;
         page = int'(rel);
         return ptw_pkg::STS_OK;
      endfunction

      // Work out the result of an accepted request and queue it
      function void note_request(logic [1:0] op_in, logic [56:0] va, logic [51:0] pa,
                                 logic [63:0] fl);
         walk_result_type r;
         logic [1:0] op;
         bit four;
         int lv, page, slot;
         logic [63:0] e;
         ptw_pkg::status_type st;
         op = (op_in == OP_LOOKUP_ALT) ? OP_LOOKUP : op_in;
         four = (levels != 3'(ptw_pkg::LEVEL_FIVE));
         lv = four ? 4 : 5;
         page = 0;
         r = '{ptw_pkg::STS_OK, '0, '0, '0, 1'b0, ptw_pkg::SZ_NONE, 1'b0};
         for (; lv > 2; lv--) begin
            slot = (page << 9) | int'((va >> (12 + 9 * (lv - 1))) & 57'h1ff);
            st = descend(slot, op, fl, four, page);
            if (st != ptw_pkg::STS_OK) begin
               r.st = st;
               pending_walks.push_back(r);
               return;
            end
         end
         slot = (page << 9) | int'(va[29:21]);
         e = tables[slot];
         if (op == ptw_pkg::OP_MAP && fl[ptw_pkg::BIT_PS]) begin
            e = {12'd0, pa} | fl;
            tables[slot] = e;
            r.large_pg = 1'b1;
         end else if (op != ptw_pkg::OP_MAP && e[ptw_pkg::BIT_PS]) begin
            if (op == ptw_pkg::OP_UNMAP) begin
               e[ptw_pkg::BIT_P] = 1'b0;
               tables[slot] = e;
               r.size = ptw_pkg::SZ_2M;
            end
            r.large_pg = 1'b1;
         end else begin
            st = descend(slot, op, fl, four, page);
            if (st != ptw_pkg::STS_OK) begin
               r.st = st;
               pending_walks.push_back(r);
               return;
            end
            slot = (page << 9) | int'(va[20:12]);
            e = tables[slot];
            if (op == ptw_pkg::OP_MAP) begin
               e = {12'd0, pa} | fl;
               tables[slot] = e;
            end else if (op == ptw_pkg::OP_UNMAP) begin
               e[ptw_pkg::BIT_P] = 1'b0;
               tables[slot] = e;
               r.size = ptw_pkg::SZ_4K;
            end
         end
         r.leaf = e;
         r.page = 6'(slot >> 9);
         r.idx = 9'(slot);
         r.inv = (r.size != ptw_pkg::SZ_NONE);
         pending_walks.push_back(r);
      endfunction

      // Compare a transferred result with the oldest expectation
      function void check_result(logic [ptw_pkg::RSP_DATA_W-1:0] d);
         walk_result_type x;
         if (pending_walks.size() == 0) begin
            $error("unexpected result transfer %h", d);
            errors++;
            return;
         end
         x = pending_walks.pop_front();
         status_seen[x.st]++;
         if (d[1:0] !== x.st) begin
            $error("status: expected %0d, actual %0d", x.st, d[1:0]); errors++;
         end
         if (d[65:2] !== x.leaf) begin
            $error("leaf_value: expected %h, actual %h", x.leaf, d[65:2]); errors++;
         end
         if (d[71:66] !== x.page) begin
            $error("leaf_page: expected %0d, actual %0d", x.page, d[71:66]); errors++;
         end
         if (d[80:72] !== x.idx) begin
            $error("leaf_index: expected %0d, actual %0d", x.idx, d[80:72]); errors++;
         end
         if (d[81] !== x.large_pg) begin
            $error("large_page: expected %0d, actual %0d", x.large_pg, d[81]); errors++;
         end
         if (d[83:82] !== x.size) begin
            $error("unmapped_size: expected %0d, actual %0d", x.size, d[83:82]); errors++;
         end
         if (d[84] !== x.inv) begin
            $error("invalidate_tlb: expected %0d, actual %0d", x.inv, d[84]); errors++;
         end
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [ptw_pkg::REQ_DATA_W-1:0]   req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [ptw_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                             csr_we;
   logic [ptw_pkg::CSR_IDX_W-1:0]    csr_index;
   logic [ptw_pkg::CSR_DATA_W-1:0]   csr_wdata;

   walk_scoreboard sb = new();
   int  rsp_count;
   int  hold_left;
   bit  hold_done;
   bit  burst_mode;
   int  burst_left;

   page_table_walker_unit #(.TABLE_PAGES(POOL_PAGES)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Check result transfers; stall on a rotating pattern, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_count <= 0;
         hold_left <= 0;
         hold_done <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata);
            rsp_count <= rsp_count + 1;
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (!hold_done && rsp_count == 60) begin
            hold_done <= 1'b1;
            hold_left <= 300;
            rsp_tready <= 1'b0;
         end else begin
            case ((rsp_count / 37) % 3)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) == 1);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic write_reg(logic [ptw_pkg::CSR_IDX_W-1:0] idx, logic [39:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   // Withdraw the offer and let the walker drain before touching the registers
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending_walks.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Offer one request and hold it until transferred; in burst mode, pause between bursts
   task automatic send_req(logic [1:0] op, logic [56:0] va, logic [51:0] pa, logic [63:0] fl);
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, fl, pa, va, op};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, va, pa, fl);
      if (burst_mode) begin
         if (burst_left > 0) burst_left--;
         else begin
            burst_left = $urandom_range(1, 8);
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
      end
   endtask

   function automatic logic [56:0] pick_va();
      logic [56:0] va;
      logic [8:0] ix;
      if ($urandom_range(0, 9) < 2) return 57'({$urandom, $urandom});
      va = 57'({$urandom, $urandom}) & 57'hfff;
      for (int lv = 1; lv <= 5; lv++) begin
         case ($urandom_range(0, 4))
            0: ix = 9'd0;
            1: ix = 9'd1;
            2: ix = 9'd511;
            3: ix = 9'd5;
            default: ix = 9'd300;
         endcase
         va[12 + 9 * (lv - 1) +: 9] = ix;
      end
      return va;
   endfunction

   function automatic logic [63:0] pick_flags();
      logic [63:0] fl;
      if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
      fl = 64'($urandom_range(0, 12'hfff));
      fl[ptw_pkg::BIT_P] = ($urandom_range(0, 99) < 85);
      fl[ptw_pkg::BIT_NX] = $urandom_range(0, 1);
      return fl;
   endfunction

   // Page-aligned addresses, with random low bits added half of the time
   function automatic logic [51:0] pick_pa();
      logic [51:0] pa;
      pa = 52'({$urandom, $urandom}) & ~52'hfff;
      if ($urandom_range(0, 1) == 1) pa = pa | (52'({$urandom, $urandom}) & 52'hfff);
      return pa;
   endfunction

   // Mostly maps and lookups over a small set of table paths
   task automatic random_phase(int n);
      logic [1:0] op;
      for (int i = 0; i < n; i++) begin
         burst_mode = ((i / 40) % 2 == 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: op = ptw_pkg::OP_MAP;
            4, 5: op = ptw_pkg::OP_UNMAP;
            6: op = OP_LOOKUP_ALT;
            default: op = OP_LOOKUP;
         endcase
         send_req(op, pick_va(), pick_pa(), pick_flags());
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_we <= 1'b0;
      csr_index <= ptw_pkg::REG_PAGING_LEVELS;
      csr_wdata <= '0;
      burst_mode = 1'b0;
      burst_left = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: four levels, pool at frame zero
      write_reg(ptw_pkg::REG_PAGING_LEVELS, 40'd4);
      write_reg(ptw_pkg::REG_POOL_BASE_FRAME, 40'd0);
      send_req(OP_LOOKUP, 57'h0, 52'h0, 64'h0);
      send_req(ptw_pkg::OP_UNMAP, 57'h0, 52'h0, 64'h0);
      send_req(ptw_pkg::OP_MAP, 57'h0, 52'h1000, 64'h3);
      send_req(OP_LOOKUP, 57'h0, 52'h0, 64'h0);
      send_req(ptw_pkg::OP_MAP, 57'h200000, 52'h200000, 64'h83);
      send_req(OP_LOOKUP_ALT, 57'h200000, 52'h0, 64'h0);
      send_req(ptw_pkg::OP_UNMAP, 57'h0, 52'h0, 64'h0);
      send_req(ptw_pkg::OP_UNMAP, 57'h200000, 52'h0, 64'h0);
      send_req(ptw_pkg::OP_UNMAP, 57'h200000, 52'h0, 64'h0);
      send_req(OP_LOOKUP, 57'h0, 52'h0, 64'h0);
      send_req(OP_LOOKUP, 57'h200000, 52'h0, 64'h0);
      send_req(ptw_pkg::OP_MAP, 57'h200000, 52'h200000, 64'h83);
      // Small map over a present large entry treats it as a table pointer
      send_req(ptw_pkg::OP_MAP, 57'h201000, 52'h5000, 64'h3);
      // Address bits in the flags leak into the created tables
      send_req(ptw_pkg::OP_MAP, 57'h40000000, 52'h7000, 64'h000f_ffff_ffff_f003);
      send_req(OP_LOOKUP, 57'h40000000, 52'h0, 64'h0);
      send_req(ptw_pkg::OP_MAP, {57{1'b1}}, {52{1'b1}}, {64{1'b1}});
      send_req(ptw_pkg::OP_MAP, 57'h1ff_ffff_ffff_f000, {52{1'b1}}, 64'h8000_0000_0000_0183);
      send_req(OP_LOOKUP_ALT, 57'h1ff_ffff_ffff_f000, 52'h0, 64'h0);
      send_req(ptw_pkg::OP_UNMAP, 57'h1ff_ffff_ffff_f000, 52'h0, 64'h0);
      random_phase(140);
      wait_idle();

      // Five levels, pool base at the top of the frame space
      write_reg(ptw_pkg::REG_PAGING_LEVELS, 40'd5);
      write_reg(ptw_pkg::REG_POOL_BASE_FRAME, {40{1'b1}});
      random_phase(120);
      wait_idle();

      // Other level codes fall back to four levels
      write_reg(ptw_pkg::REG_PAGING_LEVELS, 40'd0);
      write_reg(ptw_pkg::REG_POOL_BASE_FRAME, 40'h0012_3456);
      random_phase(60);
      wait_idle();
      write_reg(ptw_pkg::REG_PAGING_LEVELS, 40'd7);
      write_reg(ptw_pkg::REG_POOL_BASE_FRAME, 40'd0);
      random_phase(60);
      wait_idle();

      $display("Walks checked: %0d ok, %0d not mapped, %0d pool exhausted, %0d outside pool",
               sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3]);
      $display("Level settings 4, 5, 0 and 7; pool base at zero, top and mid frame");
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Drop the run if it hangs
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule
